// File: hw/rtl/pet_pkg.sv
`timescale 1ns / 1ps

package pet_pkg;

  // Event commands on the input word
  localparam logic [2:0] CMD_KEY_PRESS   = 3'd0;
  localparam logic [2:0] CMD_KEY_REPEAT  = 3'd1;
  localparam logic [2:0] CMD_REL_MOVE    = 3'd2;
  localparam logic [2:0] CMD_ABS_MOVE    = 3'd3;
  localparam logic [2:0] CMD_BTN_PRESS   = 3'd4;
  localparam logic [2:0] CMD_BTN_RELEASE = 3'd5;
  localparam logic [2:0] CMD_VALUATOR    = 3'd6;
  localparam logic [2:0] CMD_OTHER       = 3'd7;

  // Result kinds, devices and actuations on the output word
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_LOC    = 2'd2;

  localparam logic DEV_KEYBOARD = 1'b0;
  localparam logic DEV_POINTER  = 1'b1;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_HOLD    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_X_UNITS       = 2'd2;
  localparam logic [1:0] REG_Y_UNITS       = 2'd3;

  localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd640;
  localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd480;
  localparam logic [15:0] RST_X_UNITS       = 16'd160;
  localparam logic [15:0] RST_Y_UNITS       = 16'd160;

  // Valuator scaling: x = |v|*800/20320 = |v|*5/127, y = |v|*600/15040 = |v|*15/376.
  // Reciprocal multiply, exact floor over the full 16-bit magnitude range.
  localparam int unsigned VX_SHIFT = 25;
  localparam logic [20:0] VX_MUL   = 21'd1321045;   // 5 * ceil(2^25 / 127)
  localparam int unsigned VY_SHIFT = 28;
  localparam logic [23:0] VY_MUL   = 24'd10708875;  // 15 * ceil(2^28 / 376)
  localparam int unsigned MAG_W    = 11;            // scaled magnitude stays below 2048

  typedef enum logic [2:0] {
    OP_KEY,
    OP_BUTTON,
    OP_REL,
    OP_ABS,
    OP_VAL
  } op_kind_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        code;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic [5:0]         val_first;
    logic [5:0]         val_count;
    logic signed [15:0] val_a;
    logic signed [15:0] val_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               device;
    logic [1:0]         actuation;
    logic [31:0]        toggle_number;
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic               last;
  } out_item_t;

  // Classified event passed from the front to the back
  typedef struct packed {
    op_kind_e           kind;
    logic [1:0]         actuation;
    logic [31:0]        code;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               set_x;
    logic               set_y;
    logic               neg_x;
    logic               neg_y;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
  } op_t;

  typedef struct packed {
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [15:0] x_units_q4;
    logic [15:0] y_units_q4;
  } cfg_t;

endpackage

// File: hw/rtl/pet_if.sv
`timescale 1ns / 1ps

interface pet_in_if;
  import pet_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pet_out_if;
  import pet_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/pet_front.sv
`timescale 1ns / 1ps

module pet_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pet_in_if.sink        in_if,
  output logic          push_o,
  output pet_pkg::op_t  op_o,
  input  logic          full_i
);
  import pet_pkg::*;

  in_item_t item_q;
  logic     valid_q;
  logic     is_other;
  logic     consume;

  logic                first_is0;
  logic                first_is1;
  logic                cnt_ge1;
  logic                cnt_ge2;
  logic signed [15:0]  src_x;
  logic signed [15:0]  src_y;
  logic [15:0]         mag_x;
  logic [15:0]         mag_y;
  logic [36:0]         prod_x;
  logic [39:0]         prod_y;

  // Drop "other" events here, push everything else once the queue has room
  assign is_other    = (item_q.cmd == CMD_OTHER);
  assign consume     = valid_q && (is_other || !full_i);
  assign push_o      = valid_q && !is_other && !full_i;
  assign in_if.ready = !valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q <= in_if.payload;
    end
  end

  // Route carried valuators to the axes they drive
  assign first_is0 = (item_q.val_first == 6'd0);
  assign first_is1 = (item_q.val_first == 6'd1);
  assign cnt_ge1   = (item_q.val_count != 6'd0);
  assign cnt_ge2   = (item_q.val_count > 6'd1);
  assign src_x     = item_q.val_a;
  assign src_y     = first_is0 ? item_q.val_b : item_q.val_a;

  // Scale magnitudes; sign is restored in the back
  assign mag_x  = src_x[15] ? 16'(-src_x) : 16'(src_x);
  assign mag_y  = src_y[15] ? 16'(-src_y) : 16'(src_y);
  assign prod_x = 37'(mag_x) * 37'(VX_MUL);
  assign prod_y = 40'(mag_y) * 40'(VY_MUL);

  // Classify the held event
  always_comb begin
    op_o           = '0;
    op_o.code      = item_q.code;
    op_o.move_x    = item_q.move_x;
    op_o.move_y    = item_q.move_y;
    op_o.neg_x     = src_x[15];
    op_o.neg_y     = src_y[15];
    op_o.mag_x     = prod_x[VX_SHIFT +: MAG_W];
    op_o.mag_y     = prod_y[VY_SHIFT +: MAG_W];
    op_o.kind      = OP_KEY;
    op_o.actuation = ACT_PRESS;
    case (item_q.cmd)
      CMD_KEY_PRESS: begin
        op_o.kind      = OP_KEY;
        op_o.actuation = ACT_PRESS;
      end
      CMD_KEY_REPEAT: begin
        op_o.kind      = OP_KEY;
        op_o.actuation = ACT_HOLD;
      end
      CMD_REL_MOVE: op_o.kind = OP_REL;
      CMD_ABS_MOVE: op_o.kind = OP_ABS;
      CMD_BTN_PRESS: begin
        op_o.kind      = OP_BUTTON;
        op_o.actuation = ACT_PRESS;
      end
      CMD_BTN_RELEASE: begin
        op_o.kind      = OP_BUTTON;
        op_o.actuation = ACT_RELEASE;
      end
      CMD_VALUATOR: begin
        op_o.kind  = OP_VAL;
        op_o.set_x = first_is0 && cnt_ge1;
        op_o.set_y = (first_is1 && cnt_ge1) || (first_is0 && cnt_ge2);
      end
      default: op_o.kind = OP_KEY;
    endcase
  end

endmodule

// File: hw/rtl/pet_queue.sv
`timescale 1ns / 1ps

module pet_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pet_pkg::op_t  op_i,
  input  logic          pop_i,
  output pet_pkg::op_t  op_o,
  output logic          valid_o,
  output logic          full_o
);
  import pet_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign op_o    = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: hw/rtl/pet_back.sv
`timescale 1ns / 1ps

module pet_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pet_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  input  pet_pkg::cfg_t cfg_i,
  pet_out_if.source     out_if
);
  import pet_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOG  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_LOC  = 2'd3;

  logic [1:0]  state_q;
  logic [1:0]  state_d;
  op_kind_e    kind_q;
  logic [1:0]  act_q;
  logic [31:0] code_q;

  logic signed [15:0] pointer_x_q;
  logic signed [15:0] pointer_y_q;
  logic signed [15:0] pointer_x_d;
  logic signed [15:0] pointer_y_d;
  logic signed [31:0] loc_x_q;
  logic signed [31:0] loc_y_q;

  out_item_t out_q;
  out_item_t out_d;
  logic      out_valid_q;
  logic      slot_free;
  logic      load_tog;
  logic      load_loc;

  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic               ok_x;
  logic               ok_y;
  logic [15:0]        val_x;
  logic [15:0]        val_y;
  logic signed [16:0] px_s;
  logic signed [16:0] py_s;
  logic signed [16:0] ux_s;
  logic signed [16:0] uy_s;
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;

  assign slot_free = !out_valid_q || out_if.ready;
  assign op_pop_o  = (state_q == S_IDLE) && op_valid_i;
  assign load_tog  = (state_q == S_TOG) && slot_free;
  assign load_loc  = (state_q == S_LOC) && slot_free;

  // Relative move bounds and signed valuator positions
  assign sum_x = {pointer_x_q[15], pointer_x_q} + {op_i.move_x[15], op_i.move_x};
  assign sum_y = {pointer_y_q[15], pointer_y_q} + {op_i.move_y[15], op_i.move_y};
  assign ok_x  = !sum_x[16] && (sum_x[15:0] < {1'b0, cfg_i.screen_width});
  assign ok_y  = !sum_y[16] && (sum_y[15:0] < {1'b0, cfg_i.screen_height});
  assign val_x = op_i.neg_x ? 16'(-{5'b0, op_i.mag_x}) : {5'b0, op_i.mag_x};
  assign val_y = op_i.neg_y ? 16'(-{5'b0, op_i.mag_y}) : {5'b0, op_i.mag_y};

  // Update the pointer as an event leaves the queue
  always_comb begin
    pointer_x_d = pointer_x_q;
    pointer_y_d = pointer_y_q;
    if (op_pop_o) begin
      case (op_i.kind)
        OP_REL: begin
          if (ok_x) pointer_x_d = sum_x[15:0];
          if (ok_y) pointer_y_d = sum_y[15:0];
        end
        OP_ABS: begin
          pointer_x_d = op_i.move_x;
          pointer_y_d = op_i.move_y;
        end
        OP_VAL: begin
          if (op_i.set_x) pointer_x_d = val_x;
          if (op_i.set_y) pointer_y_d = val_y;
        end
        default: begin
          pointer_x_d = pointer_x_q;
          pointer_y_d = pointer_y_q;
        end
      endcase
    end
  end

  // Location scaling, pointer times Q.4 units
  assign px_s   = {pointer_x_q[15], pointer_x_q};
  assign py_s   = {pointer_y_q[15], pointer_y_q};
  assign ux_s   = {1'b0, cfg_i.x_units_q4};
  assign uy_s   = {1'b0, cfg_i.y_units_q4};
  assign prod_x = px_s * ux_s;
  assign prod_y = py_s * uy_s;

  // Sequence: take event, emit toggle (keys and buttons), multiply, emit location (all but keys)
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (op_pop_o) begin
          state_d = (op_i.kind == OP_KEY || op_i.kind == OP_BUTTON) ? S_TOG : S_MUL;
        end
      end
      S_TOG: begin
        if (slot_free) begin
          state_d = (kind_q == OP_KEY) ? S_IDLE : S_MUL;
        end
      end
      S_MUL: state_d = S_LOC;
      S_LOC: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Build the outgoing word
  always_comb begin
    out_d = '0;
    if (load_tog) begin
      out_d.result_kind   = (kind_q == OP_KEY) ? KIND_KEY : KIND_BUTTON;
      out_d.device        = (kind_q == OP_KEY) ? DEV_KEYBOARD : DEV_POINTER;
      out_d.actuation     = act_q;
      out_d.toggle_number = code_q;
      out_d.last          = (kind_q == OP_KEY);
    end else begin
      out_d.result_kind = KIND_LOC;
      out_d.device      = DEV_POINTER;
      out_d.actuation   = ACT_PRESS;
      out_d.loc_x       = loc_x_q;
      out_d.loc_y       = loc_y_q;
      out_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pointer_x_q <= '0;
      pointer_y_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pointer_x_q <= pointer_x_d;
      pointer_y_q <= pointer_y_d;
      if (load_tog || load_loc) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold event, product and output payloads
  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      kind_q <= op_i.kind;
      act_q  <= op_i.actuation;
      code_q <= op_i.code;
    end
    if (state_q == S_MUL) begin
      loc_x_q <= prod_x[31:0];
      loc_y_q <= prod_y[31:0];
    end
    if (load_tog || load_loc) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

`ifndef SYNTH
  a_mul_then_loc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_LOC))
    else $error("multiply step not followed by location step");

  a_loc_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_loc |=> (out_valid_q && out_q.last && out_q.result_kind == KIND_LOC))
    else $error("location word not presented as final word");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> (state_q == S_TOG || state_q == S_MUL))
    else $error("taken event did not start a sequence");
`endif

endmodule

// File: hw/rtl/pointer_event_translator_core.sv
`timescale 1ns / 1ps

// Pointer event translator. Raw key, move, button and valuator events come in
// on in_if; key/button toggles and scaled pointer locations go out on out_if,
// a button event giving a toggle word and then a location word. The front
// registers and classifies an event and scales valuators; a short queue
// decouples it from the back sequencer, which updates the pointer as it takes
// an event and emits words: a key event passes the take and toggle steps, a
// move or valuator event the take, multiply and location steps, and a button
// event all four, each word step waiting while the output is stalled. Other
// events are dropped in the front and give no word. Configuration registers
// sit on an APB port at byte addresses 0, 4, 8 and 12.
module pointer_event_translator_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pet_in_if.sink      in_if,
  pet_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pet_pkg::*;

  logic [14:0] screen_width_q;
  logic [14:0] screen_height_q;
  logic [15:0] x_units_q;
  logic [15:0] y_units_q;
  logic        cfg_write;
  logic [1:0]  reg_index;
  cfg_t        cfg;

  logic push;
  logic full;
  logic pop;
  logic op_valid;
  op_t  front_op;
  op_t  queue_op;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
      x_units_q       <= RST_X_UNITS;
      y_units_q       <= RST_Y_UNITS;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[14:0];
        REG_SCREEN_HEIGHT: screen_height_q <= pwdata[14:0];
        REG_X_UNITS:       x_units_q       <= pwdata[15:0];
        REG_Y_UNITS:       y_units_q       <= pwdata[15:0];
        default:           x_units_q       <= x_units_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_index)
      REG_SCREEN_WIDTH:  prdata = {17'b0, screen_width_q};
      REG_SCREEN_HEIGHT: prdata = {17'b0, screen_height_q};
      REG_X_UNITS:       prdata = {16'b0, x_units_q};
      REG_Y_UNITS:       prdata = {16'b0, y_units_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg.screen_width  = screen_width_q;
  assign cfg.screen_height = screen_height_q;
  assign cfg.x_units_q4    = x_units_q;
  assign cfg.y_units_q4    = y_units_q;

  pet_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .push_o (push),
    .op_o   (front_op),
    .full_i (full)
  );

  pet_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .op_o    (queue_op),
    .valid_o (op_valid),
    .full_o  (full)
  );

  pet_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (queue_op),
    .op_valid_i (op_valid),
    .op_pop_o   (pop),
    .cfg_i      (cfg),
    .out_if     (out_if)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pet_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pet_in_if  in_bus ();
  pet_out_if out_bus ();

  pointer_event_translator_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and the pointer position
  cfg_t               regs;
  logic signed [15:0] ptr_x;
  logic signed [15:0] ptr_y;

  out_item_t expected_words[$];

  int failures       = 0;
  int words_checked  = 0;
  int settings_used  = 0;
  int events_by_cmd[8];

  // Traffic shaping knobs for the sender task and the receiver process
  bit sender_gaps = 1'b1;
  int burst_left  = 0;
  bit rx_stalls   = 1'b1;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the output on a run-length pattern, or hold it off on request
  initial begin : rx_pattern
    int run;
    bit stalling;
    run = 0;
    stalling = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (!rx_stalls) begin
        out_bus.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          stalling = !stalling;
          run = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        run--;
        out_bus.ready <= !stalling;
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic string describe(input out_item_t w);
    return $sformatf("kind=%0d dev=%0d act=%0d num=%h x=%0d y=%0d last=%0d",
                     w.result_kind, w.device, w.actuation, w.toggle_number,
                     w.loc_x, w.loc_y, w.last);
  endfunction

  // Count a failure, print only the first few
  function automatic void flag(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Append one word at the tail of the expected stream
  function automatic void queue_word(input out_item_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic out_item_t location_word();
    out_item_t w;
    w = '0;
    w.result_kind = KIND_LOC;
    w.device      = DEV_POINTER;
    w.actuation   = ACT_PRESS;
    w.loc_x       = int'(ptr_x) * int'(regs.x_units_q4);
    w.loc_y       = int'(ptr_y) * int'(regs.y_units_q4);
    w.last        = 1'b1;
    return w;
  endfunction

  // Tablet scaling: 800/20320 on x, 600/15040 on y, truncated toward zero
  function automatic void set_valuator(input int number, input logic signed [15:0] v);
    if (number == 0) ptr_x = 16'((int'(v) * 800) / 20320);
    else if (number == 1) ptr_y = 16'((int'(v) * 600) / 15040);
  endfunction

  // Advance the pointer state and queue the words one event produces
  function automatic void translate_event(input in_item_t ev);
    out_item_t w;
    int nx;
    int ny;
    w = '0;
    case (ev.cmd)
      CMD_KEY_PRESS, CMD_KEY_REPEAT: begin
        w.result_kind   = KIND_KEY;
        w.device        = DEV_KEYBOARD;
        w.actuation     = (ev.cmd == CMD_KEY_PRESS) ? ACT_PRESS : ACT_HOLD;
        w.toggle_number = ev.code;
        w.last          = 1'b1;
        queue_word(w);
      end
      CMD_REL_MOVE: begin
        nx = int'(ptr_x) + int'(ev.move_x);
        ny = int'(ptr_y) + int'(ev.move_y);
        if (nx >= 0 && nx < int'(regs.screen_width)) ptr_x = 16'(nx);
        if (ny >= 0 && ny < int'(regs.screen_height)) ptr_y = 16'(ny);
        queue_word(location_word());
      end
      CMD_ABS_MOVE: begin
        ptr_x = ev.move_x;
        ptr_y = ev.move_y;
        queue_word(location_word());
      end
      CMD_BTN_PRESS, CMD_BTN_RELEASE: begin
        w.result_kind   = KIND_BUTTON;
        w.device        = DEV_POINTER;
        w.actuation     = (ev.cmd == CMD_BTN_PRESS) ? ACT_PRESS : ACT_RELEASE;
        w.toggle_number = ev.code;
        w.last          = 1'b0;
        queue_word(w);
        queue_word(location_word());
      end
      CMD_VALUATOR: begin
        if (ev.val_count >= 1) set_valuator(int'(ev.val_first), ev.val_a);
        if (ev.val_count >= 2) set_valuator(int'(ev.val_first) + 1, ev.val_b);
        queue_word(location_word());
      end
      default: ;
    endcase
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : word_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = out_bus.payload;
      if (expected_words.size() == 0) begin
        flag({"unexpected word ", describe(got)});
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.result_kind !== want.result_kind || got.device !== want.device ||
            got.actuation !== want.actuation ||
            got.toggle_number !== want.toggle_number ||
            got.loc_x !== want.loc_x || got.loc_y !== want.loc_y ||
            got.last !== want.last) begin
          flag({"word mismatch: want ", describe(want), " got ", describe(got)});
        end
      end
    end
  end

  function automatic in_item_t make_event(input logic [2:0] cmd, input logic [31:0] code,
                                          input int mx, input int my,
                                          input int first, input int count,
                                          input int va, input int vb);
    in_item_t ev;
    ev.cmd       = cmd;
    ev.code      = code;
    ev.move_x    = 16'(mx);
    ev.move_y    = 16'(my);
    ev.val_first = 6'(first);
    ev.val_count = 6'(count);
    ev.val_a     = 16'(va);
    ev.val_b     = 16'(vb);
    return ev;
  endfunction

  // Mostly well-formed events with random content, some pure noise
  function automatic in_item_t random_event();
    in_item_t ev;
    int pick;
    ev.cmd       = 3'($urandom);
    ev.code      = $urandom;
    ev.move_x    = 16'($urandom);
    ev.move_y    = 16'($urandom);
    ev.val_first = 6'($urandom);
    ev.val_count = 6'($urandom_range(0, 32));
    ev.val_a     = 16'($urandom);
    ev.val_b     = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      ev.cmd = $urandom_range(0, 1) ? CMD_KEY_REPEAT : CMD_KEY_PRESS;
    end else if (pick < 35) begin
      ev.cmd = CMD_REL_MOVE;
      if ($urandom_range(0, 3) != 0) begin
        ev.move_x = 16'(int'($urandom_range(0, 64)) - 32);
        ev.move_y = 16'(int'($urandom_range(0, 64)) - 32);
      end
    end else if (pick < 50) begin
      ev.cmd = CMD_ABS_MOVE;
      if ($urandom_range(0, 3) != 0 && regs.screen_width != 0 && regs.screen_height != 0) begin
        ev.move_x = 16'($urandom_range(0, int'(regs.screen_width) - 1));
        ev.move_y = 16'($urandom_range(0, int'(regs.screen_height) - 1));
      end
    end else if (pick < 65) begin
      ev.cmd = $urandom_range(0, 1) ? CMD_BTN_RELEASE : CMD_BTN_PRESS;
      if ($urandom_range(0, 1)) ev.code = $urandom_range(0, 7);
    end else if (pick < 85) begin
      ev.cmd = CMD_VALUATOR;
      if ($urandom_range(0, 9) < 7) ev.val_first = 6'($urandom_range(0, 2));
      if ($urandom_range(0, 4) != 0) ev.val_count = 6'($urandom_range(0, 3));
    end else if (pick < 88) begin
      ev.cmd = CMD_OTHER;
    end
    return ev;
  endfunction

  // Offer one word and hold it until accepted; idle between bursts when gaps are on
  task automatic send_event(input in_item_t ev);
    in_bus.valid   <= 1'b1;
    in_bus.payload <= ev;
    do @(posedge clk); while (!in_bus.ready);
    translate_event(ev);
    events_by_cmd[ev.cmd]++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        burst_left = $urandom_range(0, 7);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_register(input logic [1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      flag($sformatf("register %0d read %h, want %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] held;
    case (idx)
      REG_SCREEN_WIDTH:  regs.screen_width  = value[14:0];
      REG_SCREEN_HEIGHT: regs.screen_height = value[14:0];
      REG_X_UNITS:       regs.x_units_q4    = value;
      default:           regs.y_units_q4    = value;
    endcase
    held = (idx == REG_SCREEN_WIDTH || idx == REG_SCREEN_HEIGHT) ?
           {17'b0, value[14:0]} : {16'b0, value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    read_register(idx, held);
  endtask

  task automatic apply_settings(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] xu, input logic [15:0] yu);
    settle();
    write_register(REG_SCREEN_WIDTH, w);
    write_register(REG_SCREEN_HEIGHT, h);
    write_register(REG_X_UNITS, xu);
    write_register(REG_Y_UNITS, yu);
    settings_used++;
  endtask

  task automatic test_reset_registers();
    read_register(REG_SCREEN_WIDTH, {17'b0, RST_SCREEN_WIDTH});
    read_register(REG_SCREEN_HEIGHT, {17'b0, RST_SCREEN_HEIGHT});
    read_register(REG_X_UNITS, {16'b0, RST_X_UNITS});
    read_register(REG_Y_UNITS, {16'b0, RST_Y_UNITS});
  endtask

  task automatic test_directed_events();
    send_event(make_event(CMD_KEY_PRESS, 32'h0, 0, 0, 0, 0, 0, 0));
    send_event(make_event(CMD_KEY_REPEAT, 32'hFFFF_FFFF, -1, -1, 63, 32, -1, -1));
    send_event(make_event(CMD_ABS_MOVE, 32'h0, 32767, -32768, 0, 0, 0, 0));
    send_event(make_event(CMD_ABS_MOVE, 32'h0, 0, 0, 0, 0, 0, 0));
    // right at the screen edge, then one past it on both axes
    send_event(make_event(CMD_REL_MOVE, 32'h0, 639, 479, 0, 0, 0, 0));
    send_event(make_event(CMD_REL_MOVE, 32'h0, 1, 1, 0, 0, 0, 0));
    // x goes negative and stays put, y moves
    send_event(make_event(CMD_REL_MOVE, 32'h0, -640, -10, 0, 0, 0, 0));
    send_event(make_event(CMD_BTN_PRESS, 32'h1, 0, 0, 0, 0, 0, 0));
    send_event(make_event(CMD_BTN_RELEASE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 0, 0, 1000, 1000));
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 0, 1, 32767, 0));
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 0, 2, -32768, 32767));
    // second value lands on valuator two and is ignored
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 1, 2, -32768, 123));
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 63, 32, 500, 500));
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 2, 2, 500, 500));
    // small negatives truncate toward zero
    send_event(make_event(CMD_VALUATOR, 32'h0, 0, 0, 0, 2, -26, -26));
    send_event(make_event(CMD_OTHER, 32'hDEAD_BEEF, -5, 7, 0, 2, 99, 99));
  endtask

  task automatic test_register_extremes();
    // zero screen size rejects every relative move
    apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_event(make_event(CMD_ABS_MOVE, 32'h0, 5, 5, 0, 0, 0, 0));
    send_event(make_event(CMD_REL_MOVE, 32'h0, -5, -5, 0, 0, 0, 0));
    send_event(make_event(CMD_ABS_MOVE, 32'h0, -32768, -32768, 0, 0, 0, 0));
    send_event(make_event(CMD_BTN_PRESS, 32'h2, 0, 0, 0, 0, 0, 0));
    apply_settings(16'd1, 16'd1, 16'd0, 16'd0);
    send_event(make_event(CMD_REL_MOVE, 32'h0, 32767, 32767, 0, 0, 0, 0));
    send_event(make_event(CMD_ABS_MOVE, 32'h0, 0, 0, 0, 0, 0, 0));
    send_event(make_event(CMD_REL_MOVE, 32'h0, 1, 0, 0, 0, 0, 0));
    // bit 15 of the size registers is dropped
    apply_settings(16'hFFFF, 16'h7FFF, 16'd1, 16'd16);
    send_event(make_event(CMD_REL_MOVE, 32'h0, 32767, 32767, 0, 0, 0, 0));
    send_event(make_event(CMD_REL_MOVE, 32'h0, 32766, 32766, 0, 0, 0, 0));
    send_event(make_event(CMD_REL_MOVE, 32'h0, -32768, -32768, 0, 0, 0, 0));
    apply_settings(16'd640, 16'd480, 16'd160, 16'd160);
  endtask

  task automatic test_random_default();
    repeat (400) send_event(random_event());
  endtask

  task automatic test_random_settings();
    logic [15:0] w;
    logic [15:0] h;
    repeat (4) begin
      w = $urandom_range(0, 1) ? 16'($urandom_range(1, 2048)) : 16'($urandom_range(1, 32767));
      h = $urandom_range(0, 1) ? 16'($urandom_range(1, 2048)) : 16'($urandom_range(1, 32767));
      apply_settings(w, h, 16'($urandom), 16'($urandom));
      repeat (150) send_event(random_event());
    end
  endtask

  task automatic test_full_rate();
    sender_gaps = 1'b0;
    rx_stalls   = 1'b0;
    repeat (200) send_event(random_event());
    sender_gaps = 1'b1;
    rx_stalls   = 1'b1;
  endtask

  // Hold the output off long enough for the block to back up its input
  task automatic test_output_holdoff();
    settle();
    sender_gaps = 1'b0;
    hold_cycles = 400;
    repeat (40) send_event(random_event());
    sender_gaps = 1'b1;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.payload <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    regs.screen_width  = RST_SCREEN_WIDTH;
    regs.screen_height = RST_SCREEN_HEIGHT;
    regs.x_units_q4    = RST_X_UNITS;
    regs.y_units_q4    = RST_Y_UNITS;
    ptr_x = '0;
    ptr_y = '0;
    foreach (events_by_cmd[i]) events_by_cmd[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_registers();
    test_directed_events();
    test_register_extremes();
    test_random_default();
    test_random_settings();
    test_full_rate();
    test_output_holdoff();
    settle();

    if (expected_words.size() != 0)
      flag($sformatf("%0d expected words never arrived", expected_words.size()));
    $display("Covered %0d key, %0d move, %0d button, %0d valuator and %0d ignored events",
             events_by_cmd[CMD_KEY_PRESS] + events_by_cmd[CMD_KEY_REPEAT],
             events_by_cmd[CMD_REL_MOVE] + events_by_cmd[CMD_ABS_MOVE],
             events_by_cmd[CMD_BTN_PRESS] + events_by_cmd[CMD_BTN_RELEASE],
             events_by_cmd[CMD_VALUATOR], events_by_cmd[CMD_OTHER]);
    $display("Checked %0d output words across %0d register settings, %0d failures",
             words_checked, settings_used + 1, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
